@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ hw/rtl/mpr_pkg.sv @@
`timescale 1ns / 1ps
package mpr_pkg;

   localparam int unsigned REG_COUNT   = 8;
   localparam int unsigned REG_IX_W    = 3;
   localparam int unsigned PADDR_W     = 6;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [63:0] NODE_RESET  = 64'h1120_0010_1120_0010;

   localparam logic [7:0] STATUS_REALTIME = 8'hF8;
   localparam logic [3:0] CIN_SYSEX_END   = 4'hF;
   localparam logic [3:0] CIN_SYSEX_LO    = 4'h4;
   localparam logic [3:0] CIN_SYSEX_HI    = 4'h7;
   localparam logic [3:0] EVENT_CHAN_LO   = 4'h8;
   localparam logic [3:0] EVENT_CHAN_HI   = 4'hE;
   localparam logic [3:0] GROUP_OSC       = 4'h4;
   localparam logic [7:0] CHN_ALL         = 8'd17;
   localparam logic [7:0] CHN_MAX         = 8'd16;
   localparam logic [7:0] PORT_MAP_LO     = 8'h10;
   localparam logic [7:0] PORT_MAP_HI     = 8'h47;

   typedef struct packed {
      logic [7:0] source_port;
      logic [3:0] code_index;
      logic [3:0] cable_number;
      logic [7:0] status_byte;
      logic [7:0] data_one;
      logic [7:0] data_two;
   } mpr_pkt_type;

   // One forwarded copy on its way from the scanner to the output stage.
   typedef struct packed {
      logic [7:0] dest_port;
      logic [3:0] code_index;
      logic [3:0] cable;
      logic [7:0] status;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic       remap;
      logic [3:0] chan;
      logic       last;
   } mpr_entry_type;

   typedef struct packed {
      logic [7:0] dest_port;
      logic [3:0] code_index;
      logic [3:0] cable;
      logic [7:0] status;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic       last;
   } mpr_result_type;

   function automatic logic is_sysex(input logic [7:0] status, input logic [3:0] cin);
      return (status < STATUS_REALTIME) &&
             ((cin == CIN_SYSEX_END) || ((cin >= CIN_SYSEX_LO) && (cin <= CIN_SYSEX_HI)));
   endfunction

   // One bit per mapped port: groups 1..4, index 0..7.
   function automatic logic [31:0] mapped_port_bit(input logic [7:0] port);
      logic [31:0] m;
      logic [1:0]  grp;
      m   = '0;
      grp = port[5:4] - 2'd1;
      if ((port >= PORT_MAP_LO) && (port <= PORT_MAP_HI) && !port[3]) begin
         m = 32'd1 << {grp, port[2:0]};
      end
      return m;
   endfunction

endpackage

@@ hw/rtl/mpr_if.sv @@
`timescale 1ns / 1ps
interface mpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_port;
   logic [3:0] code_index;
   logic [3:0] cable_number;
   logic [7:0] status_byte;
   logic [7:0] data_one;
   logic [7:0] data_two;

   modport source (output valid, source_port, code_index, cable_number, status_byte,
                   data_one, data_two, input ready);
   modport sink   (input valid, source_port, code_index, cable_number, status_byte,
                   data_one, data_two, output ready);
endinterface

interface mpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] dest_port;
   logic [3:0] out_code_index;
   logic [3:0] out_cable;
   logic [7:0] out_status;
   logic [7:0] out_data_one;
   logic [7:0] out_data_two;
   logic       last_of_run;

   modport source (output valid, dest_port, out_code_index, out_cable, out_status,
                   out_data_one, out_data_two, last_of_run, input ready);
   modport sink   (input valid, dest_port, out_code_index, out_cable, out_status,
                   out_data_one, out_data_two, last_of_run, output ready);
endinterface

@@ hw/rtl/mpr_front.sv @@
`timescale 1ns / 1ps
module mpr_front
   import mpr_pkg::*;
#(
   parameter int unsigned NODE_COUNT = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  mpr_pkt_type   req_pkt,
   input  logic [31:0]   nodes [NODE_COUNT],
   output logic          push,
   output mpr_entry_type push_entry,
   input  logic          queue_full
);

   localparam int unsigned IX_W = $clog2(NODE_COUNT);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [IX_W-1:0] ix_ff, ix_in;
   mpr_pkt_type   pkt_ff, pkt_in;
   logic [31:0]   done_ff, done_in;
   logic          pend_valid_ff, pend_valid_in;
   mpr_entry_type pend_ff, pend_in;

   logic [31:0] node;
   logic [7:0]  sport, schn, dport, dchn;
   logic [3:0]  event_nib;
   logic [31:0] mask;
   logic        active, chan_msg, send;
   mpr_entry_type cand;

   assign node  = nodes[ix_ff];
   assign sport = node[7:0];
   assign schn  = node[15:8];
   assign dport = node[23:16];
   assign dchn  = node[31:24];
   assign event_nib = pkt_ff.status_byte[7:4];
   assign mask  = mapped_port_bit(dport);

   assign active = (schn != 8'd0) && (dchn != 8'd0) && (sport == pkt_ff.source_port) &&
                   !((pkt_ff.source_port[7:4] == GROUP_OSC) && (dport[7:4] == GROUP_OSC));
   assign chan_msg = (event_nib >= EVENT_CHAN_LO) && (event_nib <= EVENT_CHAN_HI);

   always_comb begin
      send = 1'b0;
      if (active) begin
         if (chan_msg) begin
            send = (schn == CHN_ALL) ||
                   ({4'd0, pkt_ff.status_byte[3:0]} + 8'd1 == schn);
         end else begin
            send = (mask == 32'd0) || ((done_ff & mask) == 32'd0);
         end
      end
   end

   always_comb begin
      cand.dest_port  = dport;
      cand.code_index = pkt_ff.code_index;
      cand.cable      = pkt_ff.cable_number;
      cand.status     = pkt_ff.status_byte;
      cand.data_one   = pkt_ff.data_one;
      cand.data_two   = pkt_ff.data_two;
      cand.remap      = chan_msg && (dchn <= CHN_MAX);
      cand.chan       = dchn[3:0] - 4'd1;
      cand.last       = 1'b0;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      ix_in         = ix_ff;
      pkt_in        = pkt_ff;
      done_in       = done_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      push          = 1'b0;
      push_entry    = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pkt_in        = req_pkt;
               ix_in         = '0;
               done_in       = '0;
               pend_valid_in = 1'b0;
               // drop SysEx data without scanning
               if (!is_sysex(req_pkt.status_byte, req_pkt.code_index)) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // hold the node while it has a copy and the previous copy cannot leave
            if (!(send && pend_valid_ff && queue_full)) begin
               if (send) begin
                  push          = pend_valid_ff;
                  pend_in       = cand;
                  pend_valid_in = 1'b1;
                  done_in       = done_ff | mask;
               end
               if (ix_ff == IX_W'(NODE_COUNT - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  ix_in = ix_ff + IX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            push_entry.last = 1'b1;
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!queue_full) begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
      end
      ix_ff   <= ix_in;
      pkt_ff  <= pkt_in;
      done_ff <= done_in;
      pend_ff <= pend_in;
   end

endmodule

@@ hw/rtl/mpr_queue.sv @@
`timescale 1ns / 1ps
module mpr_queue
   import mpr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  mpr_entry_type push_entry,
   output logic          full,
   output logic          head_valid,
   output mpr_entry_type head_entry,
   input  logic          pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   mpr_entry_type slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = do_push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in    = do_pop  ? rd_ff + PTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ hw/rtl/mpr_back.sv @@
`timescale 1ns / 1ps
module mpr_back
   import mpr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  mpr_entry_type  head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output mpr_result_type rsp_result
);

   logic           out_valid_ff, out_valid_in;
   mpr_result_type out_ff, out_in;

   // advance whenever the output register is empty or being drained
   assign pop = head_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (pop) begin
         out_valid_in      = 1'b1;
         out_in.dest_port  = head_entry.dest_port;
         out_in.code_index = head_entry.code_index;
         out_in.cable      = head_entry.cable;
         out_in.status     = head_entry.remap ?
                             {head_entry.status[7:4], head_entry.chan} : head_entry.status;
         out_in.data_one   = head_entry.data_one;
         out_in.data_two   = head_entry.data_two;
         out_in.last       = head_entry.last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

@@ hw/rtl/midi_packet_route_table.sv @@
`timescale 1ns / 1ps
// MIDI packet router with a sixteen-node routing table.
// req_bus carries one four-byte USB MIDI packet plus the code of the port it came
// from; a transaction completes when valid and ready are both high.
// rsp_bus carries one forwarded copy per transaction, in node order, with
// last_of_run set on the final copy of a packet. A packet may give no copy.
// The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds eight
// 64-bit node registers at byte addresses 8*i; pready is always high.
// Flow: the scanner visits one node per clock while no copy is held up by a full
// queue; req ready is high only between packets, and a dropped SysEx packet is not
// scanned. Each copy waits in the scanner until the next copy is found or the scan
// ends, then moves on through the queue and the output register to rsp_bus.
// A four-entry queue and an output register sit between scanner and rsp_bus, so
// a stalled receiver only halts the scan once the queue fills.
// Reset clears the queue, the output register and the scanner, and loads every
// node register with its default (source 0x10, channel off, destination 0x20).
module midi_packet_route_table
   import mpr_pkg::*;
#(
   parameter int unsigned NODE_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   mpr_req_if.sink            req_bus,
   mpr_rsp_if.source          rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   logic [63:0]    regs_ff [REG_COUNT];
   logic [31:0]    nodes [NODE_COUNT];
   logic [REG_IX_W-1:0] reg_ix;
   logic           csr_write;
   mpr_pkt_type    req_pkt;
   logic           push, queue_full, head_valid, pop;
   mpr_entry_type  push_entry, head_entry;
   mpr_result_type rsp_result;

   assign pready    = 1'b1;
   assign reg_ix    = paddr[PADDR_W-1:3];
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = regs_ff[reg_ix];

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{default: NODE_RESET};
      end else if (csr_write) begin
         regs_ff[reg_ix] <= pwdata;
      end
   end

   for (genvar g = 0; g < NODE_COUNT; g++) begin : g_node
      assign nodes[g] = regs_ff[g / 2][(g % 2) * 32 +: 32];
   end

   assign req_pkt.source_port  = req_bus.source_port;
   assign req_pkt.code_index   = req_bus.code_index;
   assign req_pkt.cable_number = req_bus.cable_number;
   assign req_pkt.status_byte  = req_bus.status_byte;
   assign req_pkt.data_one     = req_bus.data_one;
   assign req_pkt.data_two     = req_bus.data_two;

   mpr_front #(.NODE_COUNT(NODE_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_pkt    (req_pkt),
      .nodes      (nodes),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   mpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   mpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_result (rsp_result)
   );

   assign rsp_bus.dest_port      = rsp_result.dest_port;
   assign rsp_bus.out_code_index = rsp_result.code_index;
   assign rsp_bus.out_cable      = rsp_result.cable;
   assign rsp_bus.out_status     = rsp_result.status;
   assign rsp_bus.out_data_one   = rsp_result.data_one;
   assign rsp_bus.out_data_two   = rsp_result.data_two;
   assign rsp_bus.last_of_run    = rsp_result.last;

endmodule

@@ hw/rtl/mpr_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpr_checker
   import mpr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [3:0] req_code_index,
   input logic [7:0] req_status,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last,
   input logic       pready
);

   logic req_fire, req_sysex;

   assign req_fire  = req_valid && req_ready;
   assign req_sysex = is_sysex(req_status, req_code_index);

   // Out of reset the block is empty and open for a packet.
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (!rsp_valid && req_ready))
   // A packet that is scanned keeps the front busy on the next cycle.
   `ASSERT_CLK(a_scan_busy, clock, reset, (req_fire && !req_sysex) |=> !req_ready)
   // A dropped SysEx packet leaves the front open at once.
   `ASSERT_CLK(a_sysex_open, clock, reset, (req_fire && req_sysex) |=> req_ready)
   // A stalled copy stays put, last mark included.
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_last)))
   `ASSERT_CLK(a_pready, clock, reset, pready)

endmodule

bind midi_packet_route_table mpr_checker u_mpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_code_index (req_bus.code_index),
   .req_status     (req_bus.status_byte),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_last       (rsp_bus.last_of_run),
   .pready         (pready)
);
